@@ hdl/bffa_pkg.sv @@
// Shared types and constants of the bitmap first-free allocator.
package bffa_pkg;

  localparam int unsigned NUM_W       = 11;
  localparam int unsigned WORD_BITS   = 32;
  localparam int unsigned BIT_IDX_W   = 5;
  localparam int unsigned WORD_IDX_W  = NUM_W - BIT_IDX_W;
  localparam int unsigned NUM_MAX     = (1 << NUM_W) - 1;
  localparam int unsigned LIMIT_RESET = 1024;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NONE  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  typedef struct packed {
    logic             action;
    logic [NUM_W-1:0] entry_number;
  } req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [NUM_W-1:0] granted_number;
    logic [NUM_W-1:0] free_count;
  } res_t;

  typedef struct packed {
    logic                  en;
    logic [WORD_IDX_W-1:0] idx;
    logic                  full;
  } sum_upd_t;

endpackage

@@ hdl/bffa_ram.sv @@
// Generic single-port-write, registered-read RAM.
module bffa_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/bffa_summary.sv @@
// Per-word valid and full flags of the bitmap, with first non-full word search.
module bffa_summary #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  bffa_pkg::sum_upd_t              upd_i,
  input  logic [bffa_pkg::WORD_IDX_W:0]   nwords_i,
  input  logic [bffa_pkg::WORD_IDX_W-1:0] query_i,
  output logic                            query_vld_o,
  output logic                            found_o,
  output logic [bffa_pkg::WORD_IDX_W-1:0] first_o
);
  import bffa_pkg::*;

  logic [DEPTH-1:0] valid_q, valid_d;
  logic [DEPTH-1:0] full_q, full_d;

  always_comb begin
    valid_d = valid_q;
    full_d  = full_q;
    if (upd_i.en) begin
      valid_d[upd_i.idx[AW-1:0]] = 1'b1;
      full_d[upd_i.idx[AW-1:0]]  = upd_i.full;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      full_q  <= '0;
    end else begin
      valid_q <= valid_d;
      full_q  <= full_d;
    end
  end

  assign query_vld_o = valid_q[query_i[AW-1:0]];

  always_comb begin
    found_o = 1'b0;
    first_o = '0;
    for (int w = 0; w < DEPTH; w++) begin
      if (!found_o && !full_q[w] && ((WORD_IDX_W + 1)'(w) < nwords_i)) begin
        found_o = 1'b1;
        first_o = WORD_IDX_W'(w);
      end
    end
  end

endmodule

@@ hdl/bitmap_first_free_allocator_unit.sv @@
// Top level of the bitmap first-free allocator.
// One usage bit per entry is kept in a RAM of 32-bit words; a flag per word
// marks full words so that an allocate request finds the lowest free entry
// with one word search and one read-modify-write. An allocate passes through
// accept, word search, word read-modify-write and result load, skipping the
// read-modify-write when every word below the limit is marked full; a free
// skips the word search, and a free out of range goes from accept straight to
// result load. A result still waiting on the output holds the unit in its
// result load state. A write of the limit register starts a recount of the
// used entries below the new limit, one word per cycle, during which no item
// is accepted. No clearing pass is needed after reset.
module bitmap_first_free_allocator_unit #(
  parameter int unsigned ENTRIES = 1024
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [bffa_pkg::NUM_W-1:0] cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  bffa_pkg::req_t             in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output bffa_pkg::res_t             out_data_o
);
  import bffa_pkg::*;

  localparam int unsigned ENT_CAP = (ENTRIES > NUM_MAX) ? NUM_MAX : ENTRIES;
  localparam int unsigned DEPTH   = (ENT_CAP + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [NUM_W-1:0] LIM_MAX = NUM_W'(ENT_CAP);
  localparam logic [NUM_W-1:0] LIM_RST =
    NUM_W'((ENT_CAP < LIMIT_RESET) ? ENT_CAP : LIMIT_RESET);

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_FIND    = 5'b00010,
    S_MODIFY  = 5'b00100,
    S_RESPOND = 5'b01000,
    S_RECOUNT = 5'b10000
  } state_e;

  function automatic logic [WORD_BITS-1:0] lim_mask(
    input logic [WORD_IDX_W-1:0] w,
    input logic [NUM_W-1:0]      lim
  );
    logic [WORD_BITS-1:0] m;
    if (w < lim[NUM_W-1:BIT_IDX_W]) begin
      m = '1;
    end else if (w == lim[NUM_W-1:BIT_IDX_W]) begin
      m = (WORD_BITS'(1) << lim[BIT_IDX_W-1:0]) - WORD_BITS'(1);
    end else begin
      m = '0;
    end
    return m;
  endfunction

  function automatic logic [BIT_IDX_W:0] popcount(input logic [WORD_BITS-1:0] v);
    logic [BIT_IDX_W:0] n;
    n = '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      n = n + (BIT_IDX_W + 1)'(v[b]);
    end
    return n;
  endfunction

  state_e                state_q, state_d;
  logic [NUM_W-1:0]      lim_q, lim_d;
  logic [NUM_W-1:0]      used_q, used_d;
  logic                  act_q, act_d;
  logic [WORD_IDX_W-1:0] word_q, word_d;
  logic [BIT_IDX_W-1:0]  bit_q, bit_d;
  logic                  rvld_q, rvld_d;
  status_e               stat_q, stat_d;
  logic [NUM_W-1:0]      grant_q, grant_d;
  logic [WORD_IDX_W:0]   rc_addr_q, rc_addr_d;
  logic                  rc_pend_q, rc_pend_d;
  logic [NUM_W-1:0]      rc_acc_q, rc_acc_d;
  logic                  out_valid_q, out_valid_d;
  res_t                  out_q, out_d;

  logic                  re;
  logic [WORD_IDX_W-1:0] raddr;
  logic                  we;
  logic [WORD_BITS-1:0]  wdata;
  logic [WORD_BITS-1:0]  rdata;
  sum_upd_t              upd;
  logic                  query_vld;
  logic                  found;
  logic [WORD_IDX_W-1:0] first_word;
  logic [WORD_IDX_W:0]   nwords;
  logic [NUM_W-1:0]      free_idx;
  logic [WORD_BITS-1:0]  cur_word;
  logic [WORD_BITS-1:0]  taken;
  logic                  fz_found;
  logic [BIT_IDX_W-1:0]  fz_bit;

  assign nwords = (WORD_IDX_W + 1)'(({1'b0, lim_q} + (NUM_W + 1)'(WORD_BITS - 1))
                  >> BIT_IDX_W);
  assign free_idx = in_data_i.entry_number - NUM_W'(1);
  assign cur_word = rvld_q ? rdata : '0;
  assign taken    = cur_word | ~lim_mask(word_q, lim_q);

  always_comb begin
    fz_found = 1'b0;
    fz_bit   = '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      if (!fz_found && !taken[b]) begin
        fz_found = 1'b1;
        fz_bit   = BIT_IDX_W'(b);
      end
    end
  end

  assign cfg_ready_o = (state_q == S_IDLE);
  assign in_ready_o  = (state_q == S_IDLE) && !cfg_valid_i;

  always_comb begin
    state_d     = state_q;
    lim_d       = lim_q;
    used_d      = used_q;
    act_d       = act_q;
    word_d      = word_q;
    bit_d       = bit_q;
    rvld_d      = rvld_q;
    stat_d      = stat_q;
    grant_d     = grant_q;
    rc_addr_d   = rc_addr_q;
    rc_pend_d   = rc_pend_q;
    rc_acc_d    = rc_acc_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    re          = 1'b0;
    raddr       = word_q;
    we          = 1'b0;
    wdata       = cur_word;
    upd         = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (cfg_valid_i) begin
          lim_d     = (cfg_data_i > LIM_MAX) ? LIM_MAX : cfg_data_i;
          rc_addr_d = '0;
          rc_pend_d = 1'b0;
          rc_acc_d  = '0;
          state_d   = S_RECOUNT;
        end else if (in_valid_i) begin
          act_d   = in_data_i.action;
          grant_d = '0;
          stat_d  = ST_OK;
          if (in_data_i.action == ACT_ALLOC) begin
            state_d = S_FIND;
          end else if (in_data_i.entry_number == '0 || in_data_i.entry_number > lim_q) begin
            stat_d  = ST_RANGE;
            state_d = S_RESPOND;
          end else begin
            word_d  = free_idx[NUM_W-1:BIT_IDX_W];
            bit_d   = free_idx[BIT_IDX_W-1:0];
            re      = 1'b1;
            raddr   = free_idx[NUM_W-1:BIT_IDX_W];
            rvld_d  = query_vld;
            state_d = S_MODIFY;
          end
        end
      end
      S_FIND: begin
        if (found) begin
          word_d  = first_word;
          re      = 1'b1;
          raddr   = first_word;
          rvld_d  = query_vld;
          state_d = S_MODIFY;
        end else begin
          stat_d  = ST_NONE;
          state_d = S_RESPOND;
        end
      end
      S_MODIFY: begin
        if (act_q == ACT_ALLOC) begin
          if (fz_found) begin
            wdata         = cur_word | (WORD_BITS'(1) << fz_bit);
            we            = 1'b1;
            upd.en        = 1'b1;
            upd.idx       = word_q;
            upd.full      = &wdata;
            used_d        = used_q + NUM_W'(1);
            grant_d       = {word_q, fz_bit} + NUM_W'(1);
            stat_d        = ST_OK;
          end else begin
            stat_d = ST_NONE;
          end
        end else if (cur_word[bit_q]) begin
          wdata    = cur_word & ~(WORD_BITS'(1) << bit_q);
          we       = 1'b1;
          upd.en   = 1'b1;
          upd.idx  = word_q;
          upd.full = 1'b0;
          used_d   = used_q - NUM_W'(1);
        end
        state_d = S_RESPOND;
      end
      S_RESPOND: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d          = 1'b1;
          out_d.status         = stat_q;
          out_d.granted_number = grant_q;
          out_d.free_count     = lim_q - used_q;
          state_d              = S_IDLE;
        end
      end
      S_RECOUNT: begin
        if (rc_pend_q) begin
          rc_acc_d = rc_acc_q + NUM_W'(popcount(cur_word & lim_mask(word_q, lim_q)));
        end
        if (rc_addr_q < nwords) begin
          re        = 1'b1;
          raddr     = rc_addr_q[WORD_IDX_W-1:0];
          word_d    = rc_addr_q[WORD_IDX_W-1:0];
          rvld_d    = query_vld;
          rc_pend_d = 1'b1;
          rc_addr_d = rc_addr_q + (WORD_IDX_W + 1)'(1);
        end else begin
          rc_pend_d = 1'b0;
          if (!rc_pend_q) begin
            used_d  = rc_acc_q;
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      lim_q       <= LIM_RST;
      used_q      <= '0;
      rc_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      lim_q       <= lim_d;
      used_q      <= used_d;
      rc_pend_q   <= rc_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q     <= act_d;
    word_q    <= word_d;
    bit_q     <= bit_d;
    rvld_q    <= rvld_d;
    stat_q    <= stat_d;
    grant_q   <= grant_d;
    rc_addr_q <= rc_addr_d;
    rc_acc_q  <= rc_acc_d;
    out_q     <= out_d;
  end

  bffa_summary #(
    .DEPTH (DEPTH)
  ) u_summary (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .upd_i       (upd),
    .nwords_i    (nwords),
    .query_i     (raddr),
    .query_vld_o (query_vld),
    .found_o     (found),
    .first_o     (first_word)
  );

  bffa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (word_q[AW-1:0]),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr[AW-1:0]),
    .rdata_o (rdata)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
